// File: hdl/ocb_pkg.sv
// Shared types and constants for the orbit camera basis update unit.
package ocb_pkg;

    localparam int ANGLE_W = 26;
    localparam int VEC_W   = 18;
    localparam int POS_W   = 32;

    localparam logic signed [ANGLE_W-1:0] DEG45  = 26'sd2949120;
    localparam logic signed [ANGLE_W-1:0] DEG90  = 26'sd5898240;
    localparam logic signed [ANGLE_W-1:0] DEG180 = 26'sd11796480;
    localparam logic signed [27:0]        DEG360 = 28'sd23592960;
    localparam logic signed [VEC_W-1:0]   ONE16  = 18'sd65536;

    // yaw wrap: 360 deg in Q8.16 is 45 * 2^19, so only the high part is reduced mod 45
    localparam int          WRAP_LOW_BITS = 19;
    localparam logic [23:0] WRAP_BIAS     = 24'd2949120;   // 45 * 2^16, keeps high part positive
    localparam logic [23:0] WRAP_RECIP    = 24'd11930465;  // ceil(2^29 / 45)
    localparam int          WRAP_SHIFT    = 29;
    localparam logic [23:0] WRAP_MOD      = 24'd45;

    typedef enum logic [2:0]
    {
        REG_SENS   = 3'd0,
        REG_DIST   = 3'd1,
        REG_HEIGHT = 3'd2,
        REG_FLOOR  = 3'd3,
        REG_CEIL   = 3'd4
    } reg_idx_t;

    // atan(2^-i) in Q8.16 degrees
    function automatic logic [21:0] atan_deg(input logic [4:0] i);
        logic [21:0] r;
        begin
            case (i)
                5'd0:  r = 22'd2949120;
                5'd1:  r = 22'd1740967;
                5'd2:  r = 22'd919879;
                5'd3:  r = 22'd466945;
                5'd4:  r = 22'd234379;
                5'd5:  r = 22'd117304;
                5'd6:  r = 22'd58666;
                5'd7:  r = 22'd29335;
                5'd8:  r = 22'd14668;
                5'd9:  r = 22'd7334;
                5'd10: r = 22'd3667;
                5'd11: r = 22'd1833;
                5'd12: r = 22'd917;
                5'd13: r = 22'd458;
                5'd14: r = 22'd229;
                5'd15: r = 22'd115;
                5'd16: r = 22'd57;
                5'd17: r = 22'd29;
                5'd18: r = 22'd14;
                5'd19: r = 22'd7;
                5'd20: r = 22'd4;
                5'd21: r = 22'd2;
                5'd22: r = 22'd1;
                default: r = 22'd0;
            endcase
            return r;
        end
    endfunction

    typedef struct packed
    {
        logic start;
        logic signed [ANGLE_W-1:0] angle;
    } cordic_cmd_t;

    typedef struct packed
    {
        logic done;
        logic signed [VEC_W-1:0] cos_v;
        logic signed [VEC_W-1:0] sin_v;
    } cordic_rsp_t;

endpackage

// File: hdl/ocb_cordic.sv
// Iterative rotation-mode CORDIC giving sine and cosine of a Q8.16 degree angle.
module ocb_cordic #(
    parameter int CORDIC_STEPS = 16,
    parameter int FRAC_BITS    = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ocb_pkg::cordic_cmd_t cmd,
    output ocb_pkg::cordic_rsp_t rsp
);
    import ocb_pkg::*;

    localparam int XW = FRAC_BITS + 3;
    localparam int CW = $clog2(CORDIC_STEPS + 1);
    localparam int DOWN = FRAC_BITS - 16;
    // K * 2^FRAC_BITS, rounded
    localparam longint KSCALED =
        (64'sd652032874 * (64'sd1 <<< FRAC_BITS) + (64'sd1 <<< 29)) >>> 30;

    logic signed [XW-1:0]      x_reg, x_next, y_reg, y_next;
    logic signed [ANGLE_W-1:0] z_reg, z_next;
    logic                      flip_reg, flip_next;
    logic                      busy_reg, busy_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic signed [XW-1:0]      dx, dy;
    logic signed [ANGLE_W-1:0] at;
    logic signed [VEC_W-1:0]   xq, yq;

    function automatic logic signed [VEC_W-1:0] q16(input logic signed [XW-1:0] v);
        logic signed [XW+8:0] t;
        begin
            t = (XW+9)'(v);
            if (DOWN > 0)
            begin
                t = (t + ((XW+9)'(1) <<< (DOWN > 0 ? DOWN - 1 : 0))) >>> (DOWN > 0 ? DOWN : 0);
            end
            else
            begin
                t = t <<< (DOWN < 0 ? -DOWN : 0);
            end
            if (t > (XW+9)'(65536))
            begin
                t = (XW+9)'(65536);
            end
            else if (t < -(XW+9)'(65536))
            begin
                t = -(XW+9)'(65536);
            end
            return VEC_W'(t);
        end
    endfunction

    assign dx = y_reg >>> cnt_reg;
    assign dy = x_reg >>> cnt_reg;
    assign at = ANGLE_W'(signed'({1'b0, atan_deg(5'(cnt_reg))}));
    assign xq = q16(x_reg);
    assign yq = q16(y_reg);

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        flip_next = flip_reg;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (cmd.start)
        begin
            x_next    = XW'(KSCALED);
            y_next    = '0;
            busy_next = 1'b1;
            cnt_next  = '0;
            if (cmd.angle > DEG90)
            begin
                z_next    = cmd.angle - DEG180;
                flip_next = 1'b1;
            end
            else if (cmd.angle < -DEG90)
            begin
                z_next    = cmd.angle + DEG180;
                flip_next = 1'b1;
            end
            else
            begin
                z_next    = cmd.angle;
                flip_next = 1'b0;
            end
        end
        else if (busy_reg)
        begin
            if (cnt_reg == CW'(CORDIC_STEPS))
            begin
                busy_next = 1'b0;
            end
            else
            begin
                if (!z_reg[ANGLE_W-1])
                begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - at;
                end
                else
                begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + at;
                end
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        flip_reg <= flip_next;
    end

    assign rsp.done  = busy_reg && (cnt_reg == CW'(CORDIC_STEPS));
    assign rsp.cos_v = flip_reg ? -xq : xq;
    assign rsp.sin_v = flip_reg ? -yq : yq;

endmodule

// File: hdl/orbit_camera_basis_update_unit.sv
// Orbit camera: yaw/pitch from cursor, basis vectors and position on orbit items.
// A cursor transaction (action 0) takes two delta products and one
// reciprocal product that wraps yaw into [-180,180). An orbit transaction (action 1)
// runs two passes of the shared CORDIC and seven products through one 33x33
// multiplier. s_tready is low while an item is in work and while a finished result
// waits on m_tready.
module orbit_camera_basis_update_unit #(
    parameter int CORDIC_STEPS = 16,
    parameter int FRAC_BITS    = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [167:0] s_tdata,  // action, cursor_x, cursor_y, pivot_x, pivot_y, pivot_z
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [239:0] m_tdata   // cam_x,cam_y,cam_z,fwd_x,fwd_y,fwd_z,side_x,side_z,upv_x,upv_y,upv_z
);
    import ocb_pkg::*;

    typedef enum logic [10:0]
    {
        ST_IDLE  = 11'b00000000001,
        ST_CUR1  = 11'b00000000010,
        ST_CUR2  = 11'b00000000100,
        ST_CLAMP = 11'b00000001000,
        ST_YAW   = 11'b00000010000,
        ST_PITCH = 11'b00000100000,
        ST_MUL   = 11'b00001000000,
        ST_CAM   = 11'b00010000000,
        ST_OUT   = 11'b00100000000,
        ST_WRAP  = 11'b01000000000,
        ST_YMOD  = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0] sens_reg;
    logic [30:0] dist_reg;
    logic [31:0] hgt_reg;
    logic [24:0] floor_reg, ceil_reg;

    logic signed [ANGLE_W-1:0] yaw_reg, pitch_reg;
    logic signed [31:0] pcx_reg, pcy_reg;
    logic first_reg;

    logic signed [31:0] px_reg, py_reg, pz_reg, cx_reg, cy_reg;
    logic signed [VEC_W-1:0] cyw_reg, syw_reg, cp_reg, sp_reg;
    logic signed [VEC_W-1:0] fx_reg, fz_reg, ux_reg, uz_reg;
    logic signed [33:0] mx_reg, my_reg, mz_reg;
    logic signed [41:0] dyaw_reg;
    logic [3:0] step_reg;
    logic [239:0] out_reg;
    logic out_valid_reg;

    cordic_cmd_t ccmd;
    cordic_rsp_t crsp;

    ocb_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .FRAC_BITS(FRAC_BITS)) u_cordic (
        .clk(clk), .rst_n(rst_n), .cmd(ccmd), .rsp(crsp));

    // one shared multiplier, 33x33 signed with registered product
    logic signed [32:0] ma;
    logic signed [32:0] mb;
    logic signed [65:0] prod_reg;
    logic signed [65:0] prod_rnd;
    logic signed [49:0] rnd16;

    assign prod_rnd = prod_reg + 66'sd32768;
    assign rnd16    = 50'(prod_rnd >>> 16);

    // APB
    logic wr;
    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[4:2])
            REG_SENS:   prdata = {16'd0, sens_reg};
            REG_DIST:   prdata = {1'b0, dist_reg};
            REG_HEIGHT: prdata = hgt_reg;
            REG_FLOOR:  prdata = {{7{floor_reg[24]}}, floor_reg};
            REG_CEIL:   prdata = {{7{ceil_reg[24]}}, ceil_reg};
            default:    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sens_reg  <= 16'd6554;
            dist_reg  <= 31'd327680;
            hgt_reg   <= 32'd131072;
            floor_reg <= 25'h1A60000;
            ceil_reg  <= 25'd5898240;
        end
        else if (wr && paddr[1:0] == 2'b00)
        begin
            case (paddr[4:2])
                REG_SENS:   sens_reg  <= pwdata[15:0];
                REG_DIST:   dist_reg  <= pwdata[30:0];
                REG_HEIGHT: hgt_reg   <= pwdata;
                REG_FLOOR:  floor_reg <= pwdata[24:0];
                REG_CEIL:   ceil_reg  <= pwdata[24:0];
                default:    ;
            endcase
        end
    end

    // limits
    logic signed [ANGLE_W-1:0] lo, hi, fl, ce;
    assign fl = ANGLE_W'(signed'(floor_reg));
    assign ce = ANGLE_W'(signed'(ceil_reg));
    assign lo = (fl < -DEG90) ? -DEG90 : ((fl > -DEG45) ? -DEG45 : fl);
    assign hi = (ce < DEG45) ? DEG45 : ((ce > DEG90) ? DEG90 : ce);

    // cursor arithmetic
    logic signed [32:0] dxv, dyv;
    logic signed [41:0] dpv;
    logic signed [42:0] pit;
    logic signed [50:0] dsum;
    logic [23:0] hp;
    logic [23:0] wq;
    logic [5:0]  wrem;

    assign dxv = 33'(cx_reg) - 33'(pcx_reg);
    assign dyv = 33'(pcy_reg) - 33'(cy_reg);

    always_comb
    begin
        ma = '0;
        mb = '0;
        case (state_reg)
            ST_CUR1:
            begin
                ma = dxv;
                mb = 33'(signed'({1'b0, sens_reg}));
            end
            ST_CUR2:
            begin
                ma = dyv;
                mb = 33'(signed'({1'b0, sens_reg}));
            end
            ST_WRAP:
            begin
                ma = 33'({9'd0, hp});
                mb = 33'({9'd0, WRAP_RECIP});
            end
            ST_MUL, ST_CAM:
            begin
                case (step_reg)
                    4'd0: begin ma = 33'(cp_reg); mb = 33'(cyw_reg); end
                    4'd1: begin ma = 33'(cp_reg); mb = 33'(syw_reg); end
                    4'd2: begin ma = 33'(sp_reg); mb = 33'(cyw_reg); end
                    4'd3: begin ma = 33'(sp_reg); mb = 33'(syw_reg); end
                    4'd4: begin ma = 33'({2'b00, dist_reg}); mb = 33'(fx_reg); end
                    4'd5: begin ma = 33'({2'b00, dist_reg}); mb = 33'(sp_reg); end
                    4'd6: begin ma = 33'({2'b00, dist_reg}); mb = 33'(fz_reg); end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    function automatic logic [31:0] sat32(input logic signed [51:0] v);
        begin
            if (v > 52'sd2147483647)
            begin
                return 32'h7FFFFFFF;
            end
            else if (v < -52'sd2147483648)
            begin
                return 32'h80000000;
            end
            return v[31:0];
        end
    endfunction

    logic signed [51:0] camx, camy, camz;
    assign camx = 52'(px_reg) - 52'(mx_reg);
    assign camy = 52'(py_reg) - 52'(my_reg) + 52'(signed'(hgt_reg));
    assign camz = 52'(pz_reg) - 52'(mz_reg);

    // yaw + dyaw + 180 reduced mod 360 deg: the low bits pass, the high part mod 45
    // comes from a reciprocal product that is exact over the biased range
    assign dsum = 51'(yaw_reg) + 51'(dyaw_reg) + 51'(DEG180);
    assign hp   = 24'(dsum >>> WRAP_LOW_BITS) + WRAP_BIAS;
    assign wq   = 24'(prod_reg >>> WRAP_SHIFT);
    assign wrem = 6'(hp - 24'(wq * WRAP_MOD));
    assign dpv  = 42'((prod_reg + 66'sd128) >>> 8);
    assign pit  = 43'(pitch_reg) + 43'(dpv);

    assign s_tready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    always_comb
    begin
        state_next = state_reg;
        ccmd.start = 1'b0;
        ccmd.angle = yaw_reg;
        case (state_reg)
            ST_IDLE:  if (s_tvalid && s_tready) state_next = s_tdata[0] ? ST_CLAMP : ST_CUR1;
            ST_CUR1:  state_next = ST_CUR2;
            ST_CUR2:  state_next = ST_WRAP;
            ST_WRAP:  state_next = ST_YMOD;
            ST_YMOD:  state_next = ST_IDLE;
            ST_CLAMP:
            begin
                ccmd.start = 1'b1;
                state_next = ST_YAW;
            end
            ST_YAW:
            begin
                if (crsp.done)
                begin
                    ccmd.start = 1'b1;
                    ccmd.angle = pitch_reg;
                    state_next = ST_PITCH;
                end
            end
            ST_PITCH: if (crsp.done) state_next = ST_MUL;
            ST_MUL:   if (step_reg == 4'd7) state_next = ST_CAM;
            ST_CAM:   state_next = ST_OUT;
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            yaw_reg       <= -DEG90;
            pitch_reg     <= '0;
            pcx_reg       <= '0;
            pcy_reg       <= '0;
            first_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    step_reg <= '0;
                    if (s_tvalid && s_tready && !s_tdata[0] && first_reg)
                    begin
                        pcx_reg   <= signed'(s_tdata[32:1]);
                        pcy_reg   <= signed'(s_tdata[64:33]);
                        first_reg <= 1'b0;
                    end
                end
                ST_CUR2:
                begin
                    pcx_reg <= cx_reg;
                    pcy_reg <= cy_reg;
                end
                ST_WRAP:
                begin
                    // pitch delta comes straight from the product of ST_CUR2
                    if (pit > 43'(DEG90))
                    begin
                        pitch_reg <= DEG90;
                    end
                    else if (pit < -43'(DEG90))
                    begin
                        pitch_reg <= -DEG90;
                    end
                    else
                    begin
                        pitch_reg <= ANGLE_W'(pit);
                    end
                end
                ST_YMOD:
                begin
                    yaw_reg <= signed'({1'b0, wrem, dsum[WRAP_LOW_BITS-1:0]}) - DEG180;
                end
                ST_CLAMP:
                begin
                    if (pitch_reg < lo)
                    begin
                        pitch_reg <= lo;
                    end
                    else if (pitch_reg > hi)
                    begin
                        pitch_reg <= hi;
                    end
                end
                ST_MUL:   step_reg <= step_reg + 1'b1;
                ST_OUT:   out_valid_reg <= 1'b1;
                default:  ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 66'(ma) * 66'(mb);
        if (state_reg == ST_IDLE && s_tvalid && s_tready)
        begin
            cx_reg <= signed'(s_tdata[32:1]);
            cy_reg <= signed'(s_tdata[64:33]);
            px_reg <= signed'(s_tdata[96:65]);
            py_reg <= signed'(s_tdata[128:97]);
            pz_reg <= signed'(s_tdata[160:129]);
        end
        if (state_reg == ST_CUR2)
        begin
            dyaw_reg <= 42'((prod_reg + 66'sd128) >>> 8);
        end
        if (state_reg == ST_YAW && crsp.done)
        begin
            cyw_reg <= crsp.cos_v;
            syw_reg <= crsp.sin_v;
        end
        if (state_reg == ST_PITCH && crsp.done)
        begin
            cp_reg <= crsp.cos_v;
            sp_reg <= crsp.sin_v;
        end
        // product of step k is registered in prod_reg and taken at step k+1
        if (state_reg == ST_MUL || state_reg == ST_CAM)
        begin
            case (step_reg)
                4'd1: fx_reg <= VEC_W'(rnd16);
                4'd2: fz_reg <= VEC_W'(rnd16);
                4'd3: ux_reg <= VEC_W'(-rnd16);
                4'd4: uz_reg <= VEC_W'(-rnd16);
                4'd5: mx_reg <= 34'(rnd16);
                4'd6: my_reg <= 34'(rnd16);
                4'd7: mz_reg <= 34'(rnd16);
                default: ;
            endcase
        end
        if (state_reg == ST_OUT)
        begin
            out_reg <= {uz_reg, cp_reg, ux_reg, cyw_reg, VEC_W'(-syw_reg),
                        fz_reg, sp_reg, fx_reg,
                        sat32(camz), sat32(camy), sat32(camx)};
        end
    end

    property p_pitch_range;
        @(posedge clk) disable iff (!rst_n)
        (pitch_reg <= DEG90) && (pitch_reg >= -DEG90);
    endproperty
    a_pitch_range: assert property (p_pitch_range) else $error("pitch out of range");

    property p_no_accept_while_full;
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !s_tready;
    endproperty
    a_no_accept_while_full: assert property (p_no_accept_while_full)
        else $error("input accepted with result pending");

    property p_yaw_range;
        @(posedge clk) disable iff (!rst_n)
        (yaw_reg >= -DEG180) && (yaw_reg < DEG180);
    endproperty
    a_yaw_range: assert property (p_yaw_range) else $error("yaw out of range");

endmodule

// File: test/orbit_camera_basis_update_unit_test.sv
// Testbench for the orbit camera basis update unit: directed and random checks against a predictor.
`timescale 1ns / 100ps

module orbit_camera_basis_update_unit_test;

    import ocb_pkg::*;

    localparam logic ACT_CURSOR = 1'b0;
    localparam logic ACT_ORBIT  = 1'b1;
    localparam longint D45  = 64'sd2949120;
    localparam longint D90  = 64'sd5898240;
    localparam longint D180 = 64'sd11796480;
    localparam longint D360 = 64'sd23592960;
    localparam longint UNIT = 64'sd65536;
    localparam int SETTLE_CYCLES = 80;

    typedef struct packed
    {
        logic [6:0]         pad;
        logic signed [31:0] pivot_z;
        logic signed [31:0] pivot_y;
        logic signed [31:0] pivot_x;
        logic signed [31:0] cursor_y;
        logic signed [31:0] cursor_x;
        logic               action;
    } cam_item_t;

    typedef struct packed
    {
        logic signed [17:0] upv_z;
        logic signed [17:0] upv_y;
        logic signed [17:0] upv_x;
        logic signed [17:0] side_z;
        logic signed [17:0] side_x;
        logic signed [17:0] fwd_z;
        logic signed [17:0] fwd_y;
        logic signed [17:0] fwd_x;
        logic signed [31:0] cam_z;
        logic signed [31:0] cam_y;
        logic signed [31:0] cam_x;
    } cam_basis_t;

    logic         clk;
    logic         rst_n;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid;
    logic         s_tready;
    logic [167:0] s_tdata;  // action, cursor_x, cursor_y, pivot_x, pivot_y, pivot_z
    logic         m_tvalid;
    logic         m_tready;
    logic [239:0] m_tdata;  // cam_x,cam_y,cam_z,fwd_x,fwd_y,fwd_z,side_x,side_z,upv_x,upv_y,upv_z

    orbit_camera_basis_update_unit u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // predictor state and register shadow
    logic [15:0]        sens_q;
    logic [30:0]        dist_q;
    logic signed [31:0] height_q;
    logic signed [24:0] floor_q;
    logic signed [24:0] ceil_q;
    longint             yaw_q;
    longint             pitch_q;
    longint             last_cx;
    longint             last_cy;
    bit                 first_q;

    cam_basis_t basis_expected[$];
    longint     arctan_q16[16];
    bit         quiet;
    int         mismatches;
    int         items_sent;
    int         results_seen;
    int         orbit_sent;

    initial
    begin
        arctan_q16 = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                       14668, 7334, 3667, 1833, 917, 458, 229, 115};
    end

    function automatic longint clampl(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return (a * b + 32768) >>> 16;
    endfunction

    // CORDIC rotation, angle folded into [-90,90]
    task automatic cordic_sincos(input longint ang, output longint c, output longint s);
        bit     flip;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        flip = 0;
        z = ang;
        if (z > D90)
        begin
            z -= D180;
            flip = 1;
        end
        else if (z < -D90)
        begin
            z += D180;
            flip = 1;
        end
        x = (64'sd652032874 * UNIT + (64'sd1 <<< 29)) >>> 30;
        y = 0;
        for (int i = 0; i < 16; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= arctan_q16[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                z += arctan_q16[i];
            end
        end
        x = clampl(x, -UNIT, UNIT);
        y = clampl(y, -UNIT, UNIT);
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic advance_camera(input cam_item_t it, output bit has_result,
                                  output cam_basis_t r);
        longint cx;
        longint cy;
        longint dyaw;
        longint dpitch;
        longint w;
        longint lo;
        longint hi;
        longint cyw;
        longint syw;
        longint cp;
        longint sp;
        longint fx;
        longint fz;
        longint orb_dist;
        r = '0;
        has_result = 0;
        if (it.action == ACT_CURSOR)
        begin
            cx = longint'(it.cursor_x);
            cy = longint'(it.cursor_y);
            if (first_q)
            begin
                last_cx = cx;
                last_cy = cy;
                first_q = 0;
            end
            dyaw = ((cx - last_cx) * longint'(sens_q) + 128) >>> 8;
            dpitch = ((last_cy - cy) * longint'(sens_q) + 128) >>> 8;
            last_cx = cx;
            last_cy = cy;
            w = (yaw_q + dyaw + D180) % D360;
            if (w < 0)
                w += D360;
            yaw_q = w - D180;
            pitch_q = clampl(pitch_q + dpitch, -D90, D90);
        end
        else
        begin
            has_result = 1;
            lo = clampl(longint'(floor_q), -D90, -D45);
            hi = clampl(longint'(ceil_q), D45, D90);
            orb_dist = longint'(dist_q);
            pitch_q = clampl(pitch_q, lo, hi);
            cordic_sincos(yaw_q, cyw, syw);
            cordic_sincos(pitch_q, cp, sp);
            fx = qmul(cp, cyw);
            fz = qmul(cp, syw);
            r.fwd_x = 18'(fx);
            r.fwd_y = 18'(sp);
            r.fwd_z = 18'(fz);
            r.side_x = 18'(-syw);
            r.side_z = 18'(cyw);
            r.upv_x = 18'(-qmul(sp, cyw));
            r.upv_y = 18'(cp);
            r.upv_z = 18'(-qmul(sp, syw));
            r.cam_x = 32'(clampl(longint'(it.pivot_x) - qmul(fx, orb_dist),
                                 -64'sd2147483648, 64'sd2147483647));
            r.cam_y = 32'(clampl(longint'(it.pivot_y) - qmul(sp, orb_dist)
                                 + longint'(height_q),
                                 -64'sd2147483648, 64'sd2147483647));
            r.cam_z = 32'(clampl(longint'(it.pivot_z) - qmul(fz, orb_dist),
                                 -64'sd2147483648, 64'sd2147483647));
        end
    endtask

    always #6 clk = ~clk;

    initial
    begin
        clk = 0;
        rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        s_tvalid = 0;
        s_tdata = '0;
        m_tready = 0;
    end

    // input side monitor: every accepted transaction goes through the predictor
    always @(posedge clk)
    begin
        bit         has_r;
        cam_basis_t r;
        if (rst_n && s_tvalid && s_tready)
        begin
            advance_camera(cam_item_t'(s_tdata), has_r, r);
            if (has_r)
                basis_expected.push_back(r);
        end
    end

    task automatic compare_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s at %0t: expected %0d, got %0d", name, $realtime,
                         want, got);
        end
    endtask

    // output side monitor
    always @(posedge clk)
    begin
        cam_basis_t want;
        cam_basis_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = cam_basis_t'(m_tdata);
            results_seen++;
            if (basis_expected.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction at %0t", $realtime);
            end
            else
            begin
                want = basis_expected.pop_front();
                compare_field("cam_x", want.cam_x, got.cam_x);
                compare_field("cam_y", want.cam_y, got.cam_y);
                compare_field("cam_z", want.cam_z, got.cam_z);
                compare_field("fwd_x", want.fwd_x, got.fwd_x);
                compare_field("fwd_y", want.fwd_y, got.fwd_y);
                compare_field("fwd_z", want.fwd_z, got.fwd_z);
                compare_field("side_x", want.side_x, got.side_x);
                compare_field("side_z", want.side_z, got.side_z);
                compare_field("upv_x", want.upv_x, got.upv_x);
                compare_field("upv_y", want.upv_y, got.upv_y);
                compare_field("upv_z", want.upv_z, got.upv_z);
            end
        end
    end

    // result receiver with random back-pressure
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = quiet ? 0 : $urandom_range(0, 19);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_tvalid && m_tready));
        end
    end

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 5'(idx) << 2;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            REG_SENS:   sens_q = value[15:0];
            REG_DIST:   dist_q = value[30:0];
            REG_HEIGHT: height_q = value;
            REG_FLOOR:  floor_q = value[24:0];
            REG_CEIL:   ceil_q = value[24:0];
            default: ;
        endcase
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    // valid stays high across back-to-back transactions; lowered only before a gap
    task automatic send_item(input cam_item_t it);
        int gap;
        it.pad = '0;
        s_tvalid <= 1'b1;
        s_tdata <= it;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        if (it.action == ACT_ORBIT)
            orbit_sent++;
        gap = quiet ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_cursor(input logic signed [31:0] x, input logic signed [31:0] y);
        cam_item_t it;
        it = '0;
        it.action = ACT_CURSOR;
        it.cursor_x = x;
        it.cursor_y = y;
        it.pivot_x = $urandom;
        it.pivot_y = $urandom;
        it.pivot_z = $urandom;
        send_item(it);
    endtask

    task automatic send_orbit(input logic signed [31:0] px, input logic signed [31:0] py,
                              input logic signed [31:0] pz);
        cam_item_t it;
        it = '0;
        it.action = ACT_ORBIT;
        it.cursor_x = $urandom;
        it.cursor_y = $urandom;
        it.pivot_x = px;
        it.pivot_y = py;
        it.pivot_z = pz;
        send_item(it);
    endtask

    // drain results, then let a trailing cursor transaction finish
    task automatic settle;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (basis_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_reset_defaults;
        quiet = 1;
        sens_q = 16'd6554;
        dist_q = 31'd327680;
        height_q = 32'sd131072;
        floor_q = -25'sd5898240;
        ceil_q = 25'sd5898240;
        yaw_q = -D90;
        pitch_q = 0;
        last_cx = 0;
        last_cy = 0;
        first_q = 1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // orbit before any cursor, then a first sample far from zero gives no turn
        send_orbit(0, 0, 0);
        send_cursor(32'sh7fffffff, 32'sh80000000);
        send_orbit(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
        settle();
    endtask

    task automatic test_cursor_extremes;
        quiet = 0;
        write_reg(REG_SENS, 32'hffff);
        send_cursor(32'sh80000000, 32'sh7fffffff);  // full swing: yaw wraps, pitch hits -90
        send_orbit(0, 0, 0);
        send_cursor(32'sh7fffffff, 32'sh80000000);  // pitch to +90
        send_orbit(32'sh80000000, 32'sh7fffffff, 32'sh80000000);
        settle();
        write_reg(REG_SENS, 32'h0);
        send_cursor(32'sh12345678, -32'sh1234);
        send_orbit(1, -1, 1);
        settle();
    endtask

    task automatic test_pitch_limits;
        logic [31:0] lims[6];
        lims = '{32'h1ffffff, 32'h0, 32'h0b40000, 32'hff4c0000, 32'h00000001, 32'h1000000};
        quiet = 0;
        write_reg(REG_SENS, 32'hffff);
        for (int i = 0; i < 6; i++)
        begin
            write_reg(REG_FLOOR, lims[i]);
            write_reg(REG_CEIL, lims[5 - i]);
            send_cursor(0, (i % 2) ? 32'sh7fffffff : 32'sh80000000);
            send_orbit(0, 0, 0);
            settle();
        end
    endtask

    task automatic test_position_saturation;
        quiet = 0;
        write_reg(REG_DIST, 32'h7fffffff);
        write_reg(REG_HEIGHT, 32'h7fffffff);
        send_orbit(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        send_orbit(32'sh80000000, 32'sh80000000, 32'sh80000000);
        settle();
        write_reg(REG_HEIGHT, 32'h80000000);
        write_reg(REG_DIST, 32'h0);
        send_orbit(32'sh80000000, 32'sh80000000, 32'sh80000000);
        settle();
    endtask

    // mostly smooth cursor drags with random orbit updates, plus wild jumps
    task automatic test_random_orbits;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        for (int phase = 0; phase < 5; phase++)
        begin
            write_reg(REG_SENS, phase == 0 ? 32'hffff : $urandom_range(0, 65535));
            write_reg(REG_DIST, phase == 1 ? 32'h7fffffff : $urandom_range(0, 32'h00ffffff));
            write_reg(REG_HEIGHT, phase == 2 ? 32'h80000000 : $urandom);
            write_reg(REG_FLOOR, phase == 3 ? 32'h1000000 : $urandom);
            write_reg(REG_CEIL, phase == 3 ? 32'h0b40000 : $urandom);
            cx = $urandom;
            cy = $urandom;
            for (int n = 0; n < 400; n++)
            begin
                if (n % 50 == 0)
                    quiet = ($urandom_range(0, 3) == 0);
                case ($urandom_range(0, 9))
                    0: send_cursor($urandom, $urandom);
                    1, 2, 3, 4, 5:
                    begin
                        cx = cx + $signed($urandom_range(0, 8191)) - 4096;
                        cy = cy + $signed($urandom_range(0, 8191)) - 4096;
                        send_cursor(cx, cy);
                    end
                    default: send_orbit($urandom, $urandom, $urandom);
                endcase
            end
            settle();
        end
    endtask

    initial
    begin
        mismatches = 0;
        items_sent = 0;
        results_seen = 0;
        orbit_sent = 0;
        test_reset_defaults();
        test_cursor_extremes();
        test_pitch_limits();
        test_position_saturation();
        test_random_orbits();
        $display("sent %0d transactions (%0d orbit updates), checked %0d results",
                 items_sent, orbit_sent, results_seen);
        $display("covered limits, wraps, saturation and %0d mismatches", mismatches);
        if (mismatches == 0 && basis_expected.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #30ms;
        $display("timeout");
        $display("FAILURE");
        $finish;
    end

endmodule

// File: filelist.f
hdl/ocb_pkg.sv
hdl/ocb_cordic.sv
hdl/orbit_camera_basis_update_unit.sv
test/orbit_camera_basis_update_unit_test.sv
